// File: rtl/core/c16df_pkg.sv
// shared types, codes and crc function for the packet deframer
`timescale 1ns / 1ps

package c16df_pkg;

  localparam int unsigned LEN_W = 11;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_OK      = 3'd1,
    KIND_CRCERR  = 3'd2,
    KIND_KNOCK   = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
    logic             last;
  } result_t;

  localparam logic [7:0] KNOCK1_BYTE = 8'h2a;
  localparam logic [7:0] KNOCK2_BYTE = 8'h23;

  // crc16 xmodem, one byte, nibble-table-free form
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

// File: rtl/core/crc16_packet_deframer_core.sv
// top level of the length-prefixed crc16 packet deframer
// usage:
//   s_axis carries one word per received serial byte or millisecond tick;
//   tuser = 1 marks a tick, else tdata is the received byte.
//   m_axis carries one word per result: tuser is the kind (payload byte,
//   packet ok, crc error, knock, timeout), tdata holds the payload byte and
//   the frame length, tlast marks the final word of a frame.
//   cfg_we with cfg_index 0 writes the start byte, index 1 the timeout in
//   ticks; write only while the block is idle.
// a word taken on s_axis is held in the input register; its result then passes
//   through the phase logic into the result register, which drives m_axis.
// throughput: one word per cycle while m_axis is not stalled; the input register
//   feeds the phase logic and the result register in a single pass, so every unstalled cycle may take a word.
// when m_axis is stalled the result register holds; the input register takes one
//   more word only if it is empty, then s_axis_tready drops until the result is taken.
// reset (rst, synchronous) empties both registers, returns to the start-byte
//   hunt and restores start byte 42 and timeout 500 ticks.
`timescale 1ns / 1ps

module crc16_packet_deframer_core
  import c16df_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // rx_byte[7:0]
  input  logic [0:0]    s_axis_tuser,   // func[0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata,   // data[7:0], length[18:8], zero pad
  output logic [2:0]    m_axis_tuser,   // kind[2:0]
  output logic          m_axis_tlast,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [15:0]   cfg_wdata
);

  localparam logic [0:0] REG_START   = 1'b0;
  localparam logic [0:0] REG_TIMEOUT = 1'b1;

  logic          in_valid;
  logic          in_func;
  logic [7:0]    in_byte;
  logic [7:0]    start_byte;
  logic [15:0]   timeout_ticks;
  logic          room;
  logic          advance;
  logic          res_valid;
  result_t       res;

  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser[0];
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= 8'd42;
      timeout_ticks <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:   start_byte    <= cfg_wdata[7:0];
        REG_TIMEOUT: timeout_ticks <= cfg_wdata;
        default:     start_byte    <= start_byte;
      endcase
    end
  end

  c16df_fsm #(
    .MAX_FRAME(MAX_FRAME)
  ) u_fsm (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .func         (in_func),
    .rx_byte      (in_byte),
    .start_byte   (start_byte),
    .timeout_ticks(timeout_ticks),
    .res_valid    (res_valid),
    .res          (res)
  );

  c16df_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .res_valid    (res_valid),
    .res          (res),
    .room         (room),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// File: rtl/core/c16df_fsm.sv
// frame phase tracking, crc check and idle timeout for one word per cycle while advance is high
`timescale 1ns / 1ps

module c16df_fsm
  import c16df_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          func,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    start_byte,
  input  logic [15:0]   timeout_ticks,
  output logic          res_valid,
  output result_t       res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME);
  localparam logic [16:0] SIZE_MAX = 17'(MAX_FRAME - 4);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_KNOCK1,
    PH_KNOCK2,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  phase_t             phase, phase_next;
  logic [15:0]        frame_size, frame_size_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [15:0]        crc_running, crc_running_next;
  logic [16:0]        idle_timer, idle_timer_next;
  logic [15:0]        crc_step;
  logic [15:0]        size_full;
  logic [CNT_W-1:0]   count_inc;
  logic               timed;

  assign crc_step  = crc_update(crc_running, rx_byte);
  assign size_full = {rx_byte, frame_size[7:0]};
  assign count_inc = byte_count + 1'b1;
  assign timed     = (phase == PH_KNOCK1) || (phase == PH_KNOCK2) || (phase == PH_PAYLOAD) ||
                     (phase == PH_CRC_HI) || (phase == PH_CRC_LO);

  always_comb begin
    phase_next       = phase;
    frame_size_next  = frame_size;
    byte_count_next  = byte_count;
    crc_running_next = crc_running;
    idle_timer_next  = 17'd0;
    res_valid        = 1'b0;
    res              = '{kind: KIND_DATA, data: 8'h00, length: '0, last: 1'b0};
    if (func) begin
      if (timed) begin
        idle_timer_next = idle_timer + 17'd1;
        if (idle_timer_next > {1'b0, timeout_ticks}) begin
          phase_next      = PH_HUNT;
          idle_timer_next = 17'd0;
          res_valid       = 1'b1;
          res.kind        = KIND_TIMEOUT;
          res.last        = 1'b1;
          if (phase != PH_KNOCK1 && phase != PH_KNOCK2) begin
            res.length = frame_size[LEN_W-1:0];
          end
        end
      end
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == start_byte) begin
            phase_next = PH_SIZE_LO;
          end
        end
        PH_SIZE_LO: begin
          frame_size_next  = {8'h00, rx_byte};
          crc_running_next = crc_update(16'h0000, rx_byte);
          phase_next       = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          frame_size_next  = size_full;
          crc_running_next = crc_step;
          byte_count_next  = '0;
          if (size_full == 16'h0000) begin
            phase_next = PH_KNOCK1;
          end else if ({1'b0, size_full} <= SIZE_MAX) begin
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_KNOCK1: begin
          phase_next = (rx_byte == KNOCK1_BYTE) ? PH_KNOCK2 : PH_HUNT;
        end
        PH_KNOCK2: begin
          phase_next = PH_HUNT;
          if (rx_byte == KNOCK2_BYTE) begin
            res_valid = 1'b1;
            res.kind  = KIND_KNOCK;
            res.last  = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          crc_running_next = crc_step;
          byte_count_next  = count_inc;
          if (17'(count_inc) >= {1'b0, frame_size}) begin
            phase_next = PH_CRC_HI;
          end
          res_valid = 1'b1;
          res.kind  = KIND_DATA;
          res.data  = rx_byte;
        end
        PH_CRC_HI: begin
          crc_running_next = crc_step;
          phase_next       = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_running_next = crc_step;
          phase_next       = PH_HUNT;
          res_valid        = 1'b1;
          res.kind         = (crc_step == 16'h0000) ? KIND_OK : KIND_CRCERR;
          res.length       = frame_size[LEN_W-1:0];
          res.last         = 1'b1;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      frame_size  <= 16'h0000;
      byte_count  <= '0;
      crc_running <= 16'h0000;
      idle_timer  <= 17'd0;
    end else if (advance) begin
      phase       <= phase_next;
      frame_size  <= frame_size_next;
      byte_count  <= byte_count_next;
      crc_running <= crc_running_next;
      idle_timer  <= idle_timer_next;
    end
  end

endmodule

// File: rtl/core/c16df_out_reg.sv
// result register toward the output stream
`timescale 1ns / 1ps

module c16df_out_reg
  import c16df_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          res_valid,
  input  result_t       res,
  output logic          room,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata,   // data[7:0], length[18:8], zero pad
  output logic [2:0]    m_axis_tuser,   // kind[2:0]
  output logic          m_axis_tlast
);

  result_t held;

  assign room          = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {5'b00000, held.length, held.data};
  assign m_axis_tuser  = held.kind;
  assign m_axis_tlast  = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      held <= res;
    end
  end

endmodule
